/* hw/rtl/ttw_pkg.sv */
// ----------------------------------------------------------------------------
// ttw_pkg
// Shared constants and types for the text terminal writer: screen geometry,
// character codes, request codes, sequencer states and store access bundle.
// ----------------------------------------------------------------------------
package ttw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 8;
   localparam int CELL_W  = CHAR_W + COLOR_W;
   localparam int DEPTH   = ROWS * COLUMNS;
   localparam int ADDR_W  = $clog2(DEPTH);

   localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
   localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
   localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

   localparam logic REQ_PUT  = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BLANK,
      ST_RSP
   } state_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [CELL_W-1:0] wdata;
   } ram_req_type;

endpackage

/* hw/rtl/ttw_screen_ram.sv */
// ----------------------------------------------------------------------------
// ttw_screen_ram
// Single-port screen cell store with registered read data.
// ----------------------------------------------------------------------------
module ttw_screen_ram (
   input  logic                       clock,
   input  ttw_pkg::ram_req_type       ram_req,
   output logic [ttw_pkg::CELL_W-1:0] rdata
);
   import ttw_pkg::*;

   logic [CELL_W-1:0] cells_mem [DEPTH];
   logic [CELL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         cells_mem[ram_req.addr] <= ram_req.wdata;
      end
      rdata_ff <= cells_mem[ram_req.addr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/ttw_addr_unit.sv */
// ----------------------------------------------------------------------------
// ttw_addr_unit
// Shared address unit: maps a screen row through the circular row base and
// forms the linear cell address row * COLUMNS + column.
// ----------------------------------------------------------------------------
module ttw_addr_unit (
   input  logic [ttw_pkg::ROW_W-1:0]  row,
   input  logic [ttw_pkg::COL_W-1:0]  col,
   input  logic [ttw_pkg::ROW_W-1:0]  base,
   output logic [ttw_pkg::ADDR_W-1:0] addr
);
   import ttw_pkg::*;

   localparam int SUM_W  = ROW_W + 1;
   localparam int FULL_W = ADDR_W + 2;

   logic [SUM_W-1:0]  row_sum;
   logic [SUM_W-1:0]  phys_row;
   logic [FULL_W-1:0] full_addr;

   always_comb begin
      row_sum = SUM_W'(row) + SUM_W'(base);
      if (row_sum >= SUM_W'(ROWS)) begin
         phys_row = row_sum - SUM_W'(ROWS);
      end else begin
         phys_row = row_sum;
      end
      full_addr = FULL_W'(phys_row) * FULL_W'(COLUMNS) + FULL_W'(col);
      addr      = full_addr[ADDR_W-1:0];
   end

endmodule

/* hw/rtl/text_terminal_writer_unit.sv */
// ----------------------------------------------------------------------------
// text_terminal_writer_unit
// Character-cell terminal over a circular screen store with cursor, newline,
// wrap, scroll by row rotation, and single-cell reads.
// ----------------------------------------------------------------------------
// The result strobe of a read, or of a put that does not scroll, comes in the
// cycle after the accepting edge; busy stays high until the strobe is done.
// A put that scrolls first blanks the bottom row one cell a cycle through the
// single store port, then gives its strobe. One item in flight at a time.
// Reset: clears all ROWS * COLUMNS cells of the store to 0x0720 one cell a cycle
// with busy high; configuration writes are taken throughout.
// The result strobe lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module text_terminal_writer_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_type,
   input  logic [ttw_pkg::CHAR_W-1:0]  req_char_code,
   input  logic [ttw_pkg::ROW_W-1:0]   req_read_row,
   input  logic [ttw_pkg::COL_W-1:0]   req_read_column,
   output logic                        rsp_valid,
   output logic [ttw_pkg::CELL_W-1:0]  rsp_read_data,
   output logic [ttw_pkg::ROW_W-1:0]   rsp_cursor_row,
   output logic [ttw_pkg::COL_W-1:0]   rsp_cursor_column,
   output logic                        rsp_scrolled,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ttw_pkg::COLOR_W-1:0] csr_text_color
);
   import ttw_pkg::*;

   state_type          state_ff, state_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   base_ff, base_in;
   logic [COLOR_W-1:0] color_ff;
   logic [ADDR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [COL_W-1:0]   blank_cnt_ff, blank_cnt_in;
   logic               use_rdata_ff, use_rdata_in;
   logic               scrolled_ff, scrolled_in;

   logic [ROW_W-1:0]   row_sel;
   logic [COL_W-1:0]   col_sel;
   logic [ADDR_W-1:0]  unit_addr;
   logic [CELL_W-1:0]  rdata;
   logic [COL_W:0]     col_next;
   logic               wrap;
   ram_req_type        ram_req;

   ttw_addr_unit u_addr (
      .row  (row_sel),
      .col  (col_sel),
      .base (base_ff),
      .addr (unit_addr)
   );

   ttw_screen_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rdata   (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         col_ff       <= '0;
         base_ff      <= '0;
         color_ff     <= RESET_COLOR;
         clr_cnt_ff   <= '0;
         blank_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         base_ff      <= base_in;
         clr_cnt_ff   <= clr_cnt_in;
         blank_cnt_ff <= blank_cnt_in;
         if (csr_valid && csr_ready) begin
            color_ff <= csr_text_color;
         end
      end
      use_rdata_ff <= use_rdata_in;
      scrolled_ff  <= scrolled_in;
   end

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      base_in       = base_ff;
      clr_cnt_in    = clr_cnt_ff;
      blank_cnt_in  = blank_cnt_ff;
      use_rdata_in  = use_rdata_ff;
      scrolled_in   = scrolled_ff;
      row_sel       = row_ff;
      col_sel       = col_ff;
      col_next      = {1'b0, col_ff} + (COL_W+1)'(1);
      wrap          = 1'b0;
      ram_req.we    = 1'b0;
      ram_req.addr  = unit_addr;
      ram_req.wdata = {color_ff, req_char_code};

      case (state_ff)
         ST_CLEAR: begin
            ram_req.we    = 1'b1;
            ram_req.addr  = clr_cnt_ff;
            ram_req.wdata = {RESET_COLOR, SPACE_CODE};
            clr_cnt_in    = clr_cnt_ff + ADDR_W'(1);
            if (clr_cnt_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               scrolled_in = 1'b0;
               state_in    = ST_RSP;
               if (req_type == REQ_READ) begin
                  row_sel      = req_read_row;
                  col_sel      = req_read_column;
                  use_rdata_in = (req_read_row < ROW_W'(ROWS)) &&
                                 (req_read_column < COL_W'(COLUMNS));
               end else begin
                  use_rdata_in = 1'b0;
                  if (req_char_code != NEWLINE_CODE) begin
                     ram_req.we = 1'b1;
                     wrap       = (col_next >= (COL_W+1)'(COLUMNS));
                  end else begin
                     wrap = 1'b1;
                  end
                  if (wrap) begin
                     col_in = '0;
                     if (row_ff >= ROW_W'(ROWS - 1)) begin
                        row_in       = ROW_W'(ROWS - 1);
                        base_in      = (base_ff == ROW_W'(ROWS - 1)) ? '0
                                                                     : base_ff + ROW_W'(1);
                        blank_cnt_in = '0;
                        scrolled_in  = 1'b1;
                        state_in     = ST_BLANK;
                     end else begin
                        row_in = row_ff + ROW_W'(1);
                     end
                  end else begin
                     col_in = col_next[COL_W-1:0];
                  end
               end
            end
         end
         ST_BLANK: begin
            row_sel       = ROW_W'(ROWS - 1);
            col_sel       = blank_cnt_ff;
            ram_req.we    = 1'b1;
            ram_req.wdata = {color_ff, SPACE_CODE};
            blank_cnt_in  = blank_cnt_ff + COL_W'(1);
            if (blank_cnt_ff == COL_W'(COLUMNS - 1)) begin
               state_in = ST_RSP;
            end
         end
         ST_RSP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy              = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = (state_ff == ST_RSP);
   assign rsp_read_data     = use_rdata_ff ? rdata : '0;
   assign rsp_cursor_row    = row_ff;
   assign rsp_cursor_column = col_ff;
   assign rsp_scrolled      = scrolled_ff;

endmodule

/* verif/terminal_response_checker.sv */
// ----------------------------------------------------------------------------
// terminal_response_checker
// Watches the request, response and color ports of the text terminal writer,
// keeps its own screen, cursor and color, predicts each response and
// compares it field by field in order. Reports the mismatch count upward.
// ----------------------------------------------------------------------------
module terminal_response_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic                        req_type,
   input  logic [ttw_pkg::CHAR_W-1:0]  req_char_code,
   input  logic [ttw_pkg::ROW_W-1:0]   req_read_row,
   input  logic [ttw_pkg::COL_W-1:0]   req_read_column,
   input  logic                        rsp_valid,
   input  logic [ttw_pkg::CELL_W-1:0]  rsp_read_data,
   input  logic [ttw_pkg::ROW_W-1:0]   rsp_cursor_row,
   input  logic [ttw_pkg::COL_W-1:0]   rsp_cursor_column,
   input  logic                        rsp_scrolled,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [ttw_pkg::COLOR_W-1:0] csr_text_color,
   output int                          error_count,
   output int                          checked_count,
   output int                          scroll_count,
   output int                          pending_count
);
   import ttw_pkg::*;

   typedef struct packed {
      logic [CELL_W-1:0] read_data;
      logic [ROW_W-1:0]  cursor_row;
      logic [COL_W-1:0]  cursor_column;
      logic              scrolled;
   } terminal_rsp_type;

   logic [CELL_W-1:0]  screen_model [ROWS][COLUMNS];
   logic [ROW_W-1:0]   row_now;
   logic [COL_W-1:0]   col_now;
   logic [COLOR_W-1:0] color_now;
   terminal_rsp_type   awaited_rsp_q [$];
   terminal_rsp_type   want_rsp;
   terminal_rsp_type   got_rsp;
   int                 mismatches;
   int                 checked;
   int                 scrolls;

   function automatic void clear_terminal();
      for (int r = 0; r < ROWS; r++) begin
         for (int c = 0; c < COLUMNS; c++) begin
            screen_model[r][c] = {RESET_COLOR, SPACE_CODE};
         end
      end
      row_now   = '0;
      col_now   = '0;
      color_now = RESET_COLOR;
      awaited_rsp_q.delete();
      mismatches = 0;
      checked    = 0;
      scrolls    = 0;
   endfunction

   function automatic logic next_line();
      col_now = '0;
      row_now = row_now + 1'b1;
      if (row_now >= ROWS) begin
         for (int r = 0; r < ROWS - 1; r++) begin
            for (int c = 0; c < COLUMNS; c++) begin
               screen_model[r][c] = screen_model[r+1][c];
            end
         end
         for (int c = 0; c < COLUMNS; c++) begin
            screen_model[ROWS-1][c] = {color_now, SPACE_CODE};
         end
         row_now = ROW_W'(ROWS - 1);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic terminal_rsp_type advance_terminal(
      input logic              kind,
      input logic [CHAR_W-1:0] ch,
      input logic [ROW_W-1:0]  rr,
      input logic [COL_W-1:0]  rc
   );
      terminal_rsp_type r;
      r = '0;
      if (kind == REQ_READ) begin
         if (rr < ROWS && rc < COLUMNS) r.read_data = screen_model[rr][rc];
      end else if (ch == NEWLINE_CODE) begin
         r.scrolled = next_line();
      end else begin
         screen_model[row_now][col_now] = {color_now, ch};
         col_now = col_now + 1'b1;
         if (col_now >= COLUMNS) r.scrolled = next_line();
      end
      r.cursor_row    = row_now;
      r.cursor_column = col_now;
      return r;
   endfunction

   task automatic compare_field(input string field, input int want, input int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_terminal();
      end else begin
         if (csr_valid && csr_ready) color_now = csr_text_color;
         if (rsp_valid) begin
            got_rsp = {rsp_read_data, rsp_cursor_row, rsp_cursor_column, rsp_scrolled};
            if (awaited_rsp_q.size() == 0) begin
               mismatches++;
               $display("%0t: response with no request outstanding, expected none, actual %h",
                        $time, got_rsp);
            end else begin
               want_rsp = awaited_rsp_q.pop_front();
               compare_field("read_data", int'(want_rsp.read_data),
                             int'(got_rsp.read_data));
               compare_field("cursor_row", int'(want_rsp.cursor_row),
                             int'(got_rsp.cursor_row));
               compare_field("cursor_column", int'(want_rsp.cursor_column),
                             int'(got_rsp.cursor_column));
               compare_field("scrolled", int'(want_rsp.scrolled),
                             int'(got_rsp.scrolled));
               checked++;
               if (want_rsp.scrolled) scrolls++;
            end
         end
         if (start && !busy) begin
            awaited_rsp_q.push_back(advance_terminal(req_type, req_char_code,
                                                     req_read_row, req_read_column));
         end
      end
      error_count   <= mismatches;
      checked_count <= checked;
      scroll_count  <= scrolls;
      pending_count <= awaited_rsp_q.size();
   end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Top of the text terminal writer testbench: drives puts, reads and color
// writes with random gaps over several color settings, runs a response
// checker beside the unit and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
   import ttw_pkg::*;

   localparam int PHASES          = 6;
   localparam int PHASE_ITEMS     = 272;
   localparam int MODE_SPAN       = 50;
   localparam int WATCHDOG_LIMIT  = 10000;
   localparam int SETTLE_CYCLES   = COLUMNS + 20;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_type;
   logic [CHAR_W-1:0]   req_char_code;
   logic [ROW_W-1:0]    req_read_row;
   logic [COL_W-1:0]    req_read_column;
   logic                rsp_valid;
   logic [CELL_W-1:0]   rsp_read_data;
   logic [ROW_W-1:0]    rsp_cursor_row;
   logic [COL_W-1:0]    rsp_cursor_column;
   logic                rsp_scrolled;
   logic                csr_valid;
   logic                csr_ready;
   logic [COLOR_W-1:0]  csr_text_color;

   int error_count;
   int checked_count;
   int scroll_count;
   int pending_count;
   int idle_cycles = 0;
   int items_sent  = 0;
   int reads_sent  = 0;
   int color_writes = 0;

   text_terminal_writer_unit uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_char_code     (req_char_code),
      .req_read_row      (req_read_row),
      .req_read_column   (req_read_column),
      .rsp_valid         (rsp_valid),
      .rsp_read_data     (rsp_read_data),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_scrolled      (rsp_scrolled),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_text_color    (csr_text_color)
   );

   terminal_response_checker u_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_char_code     (req_char_code),
      .req_read_row      (req_read_row),
      .req_read_column   (req_read_column),
      .rsp_valid         (rsp_valid),
      .rsp_read_data     (rsp_read_data),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_scrolled      (rsp_scrolled),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_text_color    (csr_text_color),
      .error_count       (error_count),
      .checked_count     (checked_count),
      .scroll_count      (scroll_count),
      .pending_count     (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d responses outstanding", $time, pending_count);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_color(input logic [COLOR_W-1:0] value);
      csr_valid      <= 1'b1;
      csr_text_color <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      color_writes++;
   endtask

   task automatic send_item(
      input logic              kind,
      input logic [CHAR_W-1:0] ch,
      input logic [ROW_W-1:0]  rr,
      input logic [COL_W-1:0]  rc,
      input int                gap
   );
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_type        <= kind;
      req_char_code   <= ch;
      req_read_row    <= rr;
      req_read_column <= rc;
      do @(posedge clock); while (busy);
      items_sent++;
      if (kind == REQ_READ) reads_sent++;
   endtask

   task automatic send_random_item(input int newline_pct, input bit no_gaps);
      int                pick;
      int                gap;
      logic              kind;
      logic [CHAR_W-1:0] ch;
      logic [ROW_W-1:0]  rr;
      logic [COL_W-1:0]  rc;
      pick = $urandom_range(0, 99);
      gap  = no_gaps ? 0 : $urandom_range(0, 9);
      ch   = CHAR_W'($urandom_range(0, 255));
      rr   = ROW_W'($urandom);
      rc   = COL_W'($urandom);
      if (pick < 25) begin
         kind = REQ_READ;
         if ($urandom_range(0, 9) != 0) begin
            rr = ROW_W'($urandom_range(0, ROWS - 1));
            rc = COL_W'($urandom_range(0, COLUMNS - 1));
         end
      end else begin
         kind = REQ_PUT;
         if (pick < 25 + newline_pct) ch = NEWLINE_CODE;
      end
      send_item(kind, ch, rr, rc, gap);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int newline_pct;
      bit no_gaps;
      logic [COLOR_W-1:0] color;

      reset           <= 1'b1;
      start           <= 1'b0;
      req_type        <= REQ_PUT;
      req_char_code   <= '0;
      req_read_row    <= '0;
      req_read_column <= '0;
      csr_valid       <= 1'b0;
      csr_text_color  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // recolor during the clear pass: cleared cells must keep the reset color
      write_color(8'h4F);

      send_item(REQ_READ, 8'h00, 5'd0, 7'd0, 0);
      send_item(REQ_READ, 8'h00, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1), 1);
      send_item(REQ_READ, 8'h00, ROW_W'(ROWS), 7'd0, 0);
      send_item(REQ_READ, 8'h00, 5'd0, COL_W'(COLUMNS), 2);
      send_item(REQ_READ, 8'hFF, 5'd31, 7'd127, 0);
      send_item(REQ_READ, NEWLINE_CODE, 5'd0, 7'd0, 0);
      send_item(REQ_PUT, 8'h41, 5'd31, 7'd127, 1);
      send_item(REQ_PUT, 8'h00, 5'd0, 7'd0, 0);
      send_item(REQ_PUT, 8'hFF, 5'd0, 7'd0, 0);
      send_item(REQ_READ, 8'h00, 5'd0, 7'd0, 0);
      send_item(REQ_READ, 8'h00, 5'd0, 7'd1, 3);
      send_item(REQ_READ, 8'h00, 5'd0, 7'd2, 0);
      send_item(REQ_PUT, NEWLINE_CODE, 5'd0, 7'd0, 0);
      send_item(REQ_PUT, NEWLINE_CODE, 5'd31, 7'd127, 0);
      send_item(REQ_PUT, SPACE_CODE, 5'd0, 7'd0, 1);
      send_item(REQ_PUT, 8'h7F, 5'd0, 7'd0, 0);
      send_item(REQ_PUT, 8'h80, 5'd0, 7'd0, 0);
      send_item(REQ_PUT, 8'h55, 5'd0, 7'd0, 0);
      send_item(REQ_PUT, 8'hAA, 5'd0, 7'd0, 4);
      send_item(REQ_READ, 8'h00, 5'd2, 7'd0, 0);
      send_item(REQ_READ, 8'h00, 5'd2, 7'd4, 0);
      send_item(REQ_READ, 8'h00, 5'd1, 7'd0, 0);
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         if (p == 0) color = 8'h00;
         else if (p == 1) color = 8'hFF;
         else color = COLOR_W'($urandom_range(0, 255));
         write_color(color);
         newline_pct = 15;
         no_gaps     = 1'b0;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % MODE_SPAN == 0) begin
               case ($urandom_range(0, 2))
                  0: newline_pct = 1;
                  1: newline_pct = 15;
                  default: newline_pct = 40;
               endcase
               no_gaps = ($urandom_range(0, 3) == 0);
            end
            send_random_item(newline_pct, no_gaps);
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d items (%0d reads), checked %0d responses, %0d scrolls.",
               items_sent, reads_sent, checked_count, scroll_count);
      $display("Color register written %0d times, including 0x00 and 0xFF.", color_writes);
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0t: %0d mismatches, %0d responses never arrived",
                  $time, error_count, pending_count);
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* text_terminal_writer_unit.f */
hw/rtl/ttw_pkg.sv
hw/rtl/ttw_screen_ram.sv
hw/rtl/ttw_addr_unit.sv
hw/rtl/text_terminal_writer_unit.sv
verif/terminal_response_checker.sv
verif/tb.sv
